FILE: design/trilinear_vector_field_lookup_top_assert.svh
// Assertion macros for the trilinear lookup block
`ifndef TRILINEAR_VECTOR_FIELD_LOOKUP_TOP_ASSERT_SVH
`define TRILINEAR_VECTOR_FIELD_LOOKUP_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define TVFL_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TVFL_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TVFL_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TVFL_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: design/tvfl_pkg.sv
`default_nettype none
package tvfl_pkg;

  // lattice size per axis
  localparam int POINTS_X = 32;
  localparam int POINTS_Y = 32;
  localparam int POINTS_Z = 32;

  localparam int FW = 24;   // field value width
  localparam int WW = 17;   // weight width, 1..65536
  localparam int UW = 49;   // grid coordinate width
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [UW-1:0] LIM_X = UW'(POINTS_X - 1) << 16;
  localparam logic [UW-1:0] LIM_Y = UW'(POINTS_Y - 1) << 16;
  localparam logic [UW-1:0] LIM_Z = UW'(POINTS_Z - 1) << 16;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_INV_X    = 3'd3,
    REG_INV_Y    = 3'd4,
    REG_INV_Z    = 3'd5
  } reg_idx_e;

  // one classified transaction between front and back
  typedef struct packed {
    op_e                   op;
    logic                  in_range;
    logic [4:0]            ci;
    logic [4:0]            cj;
    logic [4:0]            ck;
    logic [WW-1:0]         wx;
    logic [WW-1:0]         wy;
    logic [WW-1:0]         wz;
    logic signed [FW-1:0]  fx;
    logic signed [FW-1:0]  fy;
    logic signed [FW-1:0]  fz;
  } item_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } qstat_t;

  // a + floor(w * (b - a) / 65536)
  function automatic logic signed [FW-1:0] lerp(input logic signed [FW-1:0] a,
                                                input logic signed [FW-1:0] b,
                                                input logic [WW-1:0] w);
    logic signed [FW:0]       diff;
    logic signed [FW+WW+1:0]  prod;
    logic signed [FW+WW+1:0]  sum;
    diff = (FW+1)'(b) - (FW+1)'(a);
    prod = (FW+WW+2)'(diff) * $signed({1'b0, w});
    sum  = (prod >>> 16) + (FW+WW+2)'(a);
    return sum[FW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/tvfl_front.sv
`default_nettype none
module tvfl_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation_i,
  input  wire logic signed [31:0]            pos_x_i,
  input  wire logic signed [31:0]            pos_y_i,
  input  wire logic signed [31:0]            pos_z_i,
  input  wire logic [4:0]                    grid_i_i,
  input  wire logic [4:0]                    grid_j_i,
  input  wire logic [4:0]                    grid_k_i,
  input  wire logic signed [23:0]            field_x_i,
  input  wire logic signed [23:0]            field_y_i,
  input  wire logic signed [23:0]            field_z_i,
  input  tvfl_pkg::qstat_t                   qstat_i,
  output logic                               push_o,
  output tvfl_pkg::item_t                    item_o
);
  import tvfl_pkg::*;

  logic signed [31:0] origin_q [3];
  logic [31:0]        inv_q [3];
  logic signed [31:0] pos [3];
  logic [UW-1:0]      lim [3];

  logic               v1_q, v2_q;
  item_t              it1_q, it2_q;
  logic signed [32:0] d_q [3];
  logic               neg_q [3];
  logic [47:0]        hi_q [3];
  logic [47:0]        lo_q [3];
  logic               accept;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign lim[0] = LIM_X;
  assign lim[1] = LIM_Y;
  assign lim[2] = LIM_Z;

  // hold off while in-flight plus queued transactions would fill the queue
  assign busy   = (QCW+1)'(qstat_i.count) + (QCW+1)'(v1_q) + (QCW+1)'(v2_q)
                  >= (QCW+1)'(QDEPTH);
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        inv_q[a]    <= 32'd65536;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        REG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        REG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        REG_INV_X:    inv_q[0]    <= cfg_data_i;
        REG_INV_Y:    inv_q[1]    <= cfg_data_i;
        REG_INV_Z:    inv_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // stage 1: capture and offset from origin
  always_ff @(posedge clk_i) begin
    if (accept) begin
      it1_q <= '{op: op_e'(operation_i), in_range: 1'b0, ci: grid_i_i, cj: grid_j_i,
                 ck: grid_k_i, wx: '0, wy: '0, wz: '0, fx: field_x_i, fy: field_y_i,
                 fz: field_z_i};
      for (int a = 0; a < 3; a++) begin
        d_q[a] <= 33'(pos[a]) - 33'(origin_q[a]);
      end
    end
  end

  // stage 2: split 32x32 product into two 16x32 partial products
  always_ff @(posedge clk_i) begin
    it2_q <= it1_q;
    for (int a = 0; a < 3; a++) begin
      neg_q[a] <= d_q[a][32];
      hi_q[a]  <= d_q[a][31:16] * inv_q[a];
      lo_q[a]  <= d_q[a][15:0] * inv_q[a];
    end
  end

  // stage 3: grid coordinate, range check, cell and weight
  always_comb begin
    logic [UW-1:0] u;
    logic [23:0]   cu;
    logic [7:0]    cidx;
    logic          outside;
    logic [4:0]    c5 [3];
    logic [WW-1:0] w [3];
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      u = UW'(hi_q[a]) + UW'(lo_q[a][47:16]);
      if (neg_q[a]) u = '0;
      if (u == '0 || u > lim[a]) outside = 1'b1;
      cu    = u[23:0] - 24'd1;
      cidx  = cu[23:16];
      w[a]  = WW'(u[23:0] - {cidx, 16'd0});
      c5[a] = cidx[4:0];
    end
    item_o          = it2_q;
    item_o.in_range = !outside;
    if (it2_q.op == OP_QUERY) begin
      item_o.ci = c5[0];
      item_o.cj = c5[1];
      item_o.ck = c5[2];
      item_o.wx = w[0];
      item_o.wy = w[1];
      item_o.wz = w[2];
    end
  end

  assign push_o = v2_q;

endmodule
`default_nettype wire

FILE: design/tvfl_fifo.sv
`default_nettype none
module tvfl_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  tvfl_pkg::item_t      item_i,
  input  wire logic            pop_i,
  output tvfl_pkg::item_t      item_o,
  output tvfl_pkg::qstat_t     stat_o
);
  import tvfl_pkg::*;

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QCW-1:0] cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QAW'(1);
      if (pop_i)  rp_q <= rp_q + QAW'(1);
      cnt_q <= cnt_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  assign item_o       = mem_q[rp_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

endmodule
`default_nettype wire

FILE: design/tvfl_back.sv
`default_nettype none
module tvfl_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  tvfl_pkg::item_t          item_i,
  input  tvfl_pkg::qstat_t         qstat_i,
  output logic                     pop_o,
  output logic                     result_valid_o,
  output logic                     in_range_o,
  output logic signed [23:0]       result_x_o,
  output logic signed [23:0]       result_y_o,
  output logic signed [23:0]       result_z_o
);
  import tvfl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam logic [3:0] LAST_STEP = 4'd10;

  state_e             state_q, state_d;
  logic [3:0]         step_q;
  item_t              cur_q;
  logic [3*FW-1:0]    store_q [32768];
  logic [3*FW-1:0]    rdata_q;
  logic               mem_we;
  logic [14:0]        mem_addr;
  logic [4:0]         ai, aj, ak;
  logic [3*FW-1:0]    lo_q, c00_q, c01_q, c10_q, c11_q, c0_q, c1_q;
  logic [3*FW-1:0]    op_a, op_b, lerp_y;
  logic [WW-1:0]      op_w;
  logic               out_v_d, out_r_d;
  logic [3*FW-1:0]    out_d;

  // one-hot control
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (item_i.op == OP_QUERY && item_i.in_range) state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == LAST_STEP) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RUN) step_q <= step_q + 4'd1;
      else                   step_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
  end

  // corner address: step bits select the +1 offset on each axis
  assign ai       = cur_q.ci + 5'(step_q[2]);
  assign aj       = cur_q.cj + 5'(step_q[1]);
  assign ak       = cur_q.ck + 5'(step_q[0]);
  assign mem_we   = pop_o && item_i.op == OP_LOAD;
  assign mem_addr = mem_we ? {item_i.ci, item_i.cj, item_i.ck} : {ai, aj, ak};

  // single-port lattice store, three components per word
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_addr] <= {item_i.fx, item_i.fy, item_i.fz};
    else        rdata_q <= store_q[mem_addr];
  end

  // shared interpolation unit operand select
  always_comb begin
    op_a = lo_q;
    op_b = rdata_q;
    op_w = cur_q.wz;
    case (step_q)
      4'd5: begin
        op_a = c00_q; op_b = c01_q; op_w = cur_q.wy;
      end
      4'd9: begin
        op_a = c10_q; op_b = c11_q; op_w = cur_q.wy;
      end
      4'd10: begin
        op_a = c0_q; op_b = c1_q; op_w = cur_q.wx;
      end
      default: ;
    endcase
    for (int c = 0; c < 3; c++) begin
      lerp_y[c*FW +: FW] = lerp(op_a[c*FW +: FW], op_b[c*FW +: FW], op_w);
    end
  end

  // intermediate results by step
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      case (step_q) inside
        4'd1, 4'd3, 4'd5, 4'd7: lo_q <= rdata_q;
        default: ;
      endcase
      case (step_q)
        4'd2: c00_q <= lerp_y;
        4'd4: c01_q <= lerp_y;
        4'd5: c0_q  <= lerp_y;
        4'd6: c10_q <= lerp_y;
        4'd8: c11_q <= lerp_y;
        4'd9: c1_q  <= lerp_y;
        default: ;
      endcase
    end
  end

  // result selection
  always_comb begin
    out_v_d = 1'b0;
    out_r_d = 1'b0;
    out_d   = '0;
    if (pop_o && item_i.op == OP_QUERY && !item_i.in_range) begin
      out_v_d = 1'b1;
    end else if (state_q == ST_RUN && step_q == LAST_STEP) begin
      out_v_d = 1'b1;
      out_r_d = 1'b1;
      out_d   = lerp_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_d) begin
      in_range_o <= out_r_d;
      result_x_o <= out_d[2*FW +: FW];
      result_y_o <= out_d[FW +: FW];
      result_z_o <= out_d[0 +: FW];
    end
  end

endmodule
`default_nettype wire

FILE: design/trilinear_vector_field_lookup_top.sv
// An in-range query's result passes the 2 front stages, the queue, the pop into the back,
//   its 11 back steps and the output register; an outside query skips the back steps.
// Loads are taken one per cycle while busy is low. The back takes no new item until the eight
//   corner reads of a query through the single lattice store port and its blend steps are done.
// busy rises when the 4-entry queue plus in-flight front stages are full; results never stall.
// Reset clears control and configuration; the lattice store is not cleared.
`default_nettype none
`include "trilinear_vector_field_lookup_top_assert.svh"
module trilinear_vector_field_lookup_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [4:0]         grid_i_i,
  input  wire logic [4:0]         grid_j_i,
  input  wire logic [4:0]         grid_k_i,
  input  wire logic signed [23:0] field_x_i,
  input  wire logic signed [23:0] field_y_i,
  input  wire logic signed [23:0] field_z_i,
  output logic                    result_valid_o,
  output logic                    in_range_o,
  output logic signed [23:0]      result_x_o,
  output logic signed [23:0]      result_y_o,
  output logic signed [23:0]      result_z_o
);
  import tvfl_pkg::*;

  logic   push, pop;
  item_t  push_item, head_item;
  qstat_t qstat;
  logic   res_zero;

  tvfl_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start, .busy, .operation_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .grid_i_i, .grid_j_i, .grid_k_i, .field_x_i, .field_y_i, .field_z_i,
    .qstat_i (qstat),
    .push_o  (push),
    .item_o  (push_item)
  );

  tvfl_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  tvfl_back u_back (
    .clk_i, .rst_ni,
    .item_i  (head_item),
    .qstat_i (qstat),
    .pop_o   (pop),
    .result_valid_o, .in_range_o, .result_x_o, .result_y_o, .result_z_o
  );

  assign res_zero = (result_x_o == '0) && (result_y_o == '0) && (result_z_o == '0);

  // checks
  `TVFL_ASSERT_IMP(a_q_no_overflow, clk_i, rst_ni, push && !pop, qstat.count < QCW'(QDEPTH))
  `TVFL_ASSERT_IMP(a_q_no_underflow, clk_i, rst_ni, pop, !qstat.empty)
  `TVFL_ASSERT_IMP(a_outside_zero, clk_i, rst_ni, result_valid_o && !in_range_o, res_zero)

endmodule
`default_nettype wire
